// ----- rtl/core/tedrs_pkg.sv -----
package tedrs_pkg;

    // field widths
    localparam int unsigned PIX_W = 16;   // pixel, size and touch maximum width
    localparam int unsigned VAL_W = 32;   // event value and stored coordinate width
    localparam int unsigned POS_W = 34;   // rotated coordinate, signed
    localparam int unsigned NUM_W = 50;   // scaled product, signed
    localparam int unsigned IDX_W = 3;    // configuration index width

    // event classes and codes
    localparam logic [15:0] EVT_SYN         = 16'h0000;
    localparam logic [15:0] EVT_KEY         = 16'h0001;
    localparam logic [15:0] EVT_ABS         = 16'h0003;
    localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
    localparam logic [15:0] CODE_BTN_TOUCH  = 16'h014A;
    localparam logic [15:0] CODE_MT_SLOT    = 16'h002F;
    localparam logic [15:0] CODE_MT_POS_X   = 16'h0035;
    localparam logic [15:0] CODE_MT_POS_Y   = 16'h0036;

    // touch kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_MOVE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ORIENTATION    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOUCH_MAX_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOUCH_MAX_Y    = 3'd4;

    // orientation codes
    localparam logic [1:0] ORIENT_0   = 2'd0;
    localparam logic [1:0] ORIENT_90  = 2'd1;
    localparam logic [1:0] ORIENT_180 = 2'd2;
    localparam logic [1:0] ORIENT_270 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/tedrs_divider.sv -----
module tedrs_divider (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [tedrs_pkg::NUM_W-1:0]   num,
    input  logic        [tedrs_pkg::PIX_W-1:0]   den,
    output logic        [tedrs_pkg::PIX_W-1:0]   quo,
    output tedrs_pkg::div_stat_t                 stat
);
    import tedrs_pkg::*;

    localparam int unsigned CNT_W = $clog2(PIX_W + 1);
    localparam int unsigned HI_W  = NUM_W - PIX_W - 1;   // magnitude bits above the low word

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PIX_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  quo_reg;   // dividend bits shift out at the top, quotient in at the bottom

    logic              num_le_zero;
    logic              num_ovf;
    logic [PIX_W:0]    trial;
    logic [PIX_W:0]    diff;

    assign num_le_zero = num[NUM_W-1] || (num == '0);
    // quotient above 16 bits exactly when the high part reaches the divisor
    assign num_ovf     = (num[NUM_W-2:PIX_W] >= {{(HI_W - PIX_W){1'b0}}, den});

    assign trial = {rem_reg, quo_reg[PIX_W-1]};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num_le_zero) begin
                    quo_reg  <= '0;
                    done_reg <= 1'b1;
                end else if (num_ovf) begin
                    quo_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= num[2*PIX_W-1:PIX_W];
                    quo_reg  <= num[PIX_W-1:0];
                    cnt_reg  <= CNT_W'(PIX_W);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (!diff[PIX_W]) begin
                    rem_reg <= diff[PIX_W-1:0];
                    quo_reg <= {quo_reg[PIX_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[PIX_W-1:0];
                    quo_reg <= {quo_reg[PIX_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/core/touch_event_decoder_rotate_scale.sv -----
// Multitouch event decoder with display rotation and scaling. One event
// (type, code, value) is taken per input transfer. Key, slot and position
// events update internal state and give no result. A sync report with
// value 0 while the slot is 0 rotates the stored point by orientation,
// scales each axis by a 17-bit multiply and a restoring divide by the touch
// maximum (zero read as one), clamps to 0..65535 and offers one result
// transfer. Per axis such a frame end passes a multiply step, a divider load
// step, the divider steps and a collect step before the result is offered,
// the divider being shared by both axes; results that clamp to 0 or 65535
// skip the divider steps. The block takes no new event until the result
// transfer completes. Configuration writes are registered and must only be
// issued while idle.
module touch_event_decoder_rotate_scale (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [tedrs_pkg::IDX_W-1:0]       cfg_index,
    input  logic [tedrs_pkg::PIX_W-1:0]       cfg_wdata,
    // event input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [15:0]                       s_event_type,
    input  logic [15:0]                       s_event_code,
    input  logic signed [31:0]                s_event_value,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_touch_kind,
    output logic [tedrs_pkg::PIX_W-1:0]       m_pixel_x,
    output logic [tedrs_pkg::PIX_W-1:0]       m_pixel_y
);
    import tedrs_pkg::*;

    // configuration registers
    logic [1:0]        orientation_reg;
    logic [PIX_W-1:0]  display_width_reg;
    logic [PIX_W-1:0]  display_height_reg;
    logic [PIX_W-1:0]  touch_max_x_reg;
    logic [PIX_W-1:0]  touch_max_y_reg;

    // decoder state
    logic [VAL_W-1:0]         contact_slot_reg;
    logic signed [VAL_W-1:0]  raw_x_reg;
    logic signed [VAL_W-1:0]  raw_y_reg;
    logic [1:0]               frame_status_reg;

    // sequencer
    seq_state_t               state_reg, state_next;
    logic                     axis_reg;           // 0: X axis, 1: Y axis
    logic signed [POS_W-1:0]  rx_reg, ry_reg;
    logic [PIX_W-1:0]         size_x_reg, size_y_reg;
    logic signed [NUM_W-1:0]  product_reg;
    logic [1:0]               kind_reg;
    logic [PIX_W-1:0]         pix_x_reg, pix_y_reg;

    logic                     in_xfer;
    logic                     frame_end;
    logic                     emit;
    logic signed [POS_W-1:0]  xs, ys, mx, my;
    logic signed [POS_W-1:0]  rx_calc, ry_calc;
    logic signed [POS_W-1:0]  mul_op;
    logic signed [PIX_W:0]    mul_size;
    logic signed [NUM_W:0]    mul_full;
    logic [PIX_W-1:0]         div_den;
    logic [PIX_W-1:0]         div_quo;
    div_stat_t                div_stat;
    logic                     div_start;

    assign in_xfer   = s_valid && s_ready;
    assign frame_end = (s_event_type == EVT_SYN) && (s_event_code == CODE_SYN_REPORT)
                       && (s_event_value == '0);
    assign emit      = in_xfer && frame_end && (contact_slot_reg == '0);

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orientation_reg    <= ORIENT_0;
            display_width_reg  <= 16'd1080;
            display_height_reg <= 16'd2400;
            touch_max_x_reg    <= 16'd4095;
            touch_max_y_reg    <= 16'd4095;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ORIENTATION:    orientation_reg    <= cfg_wdata[1:0];
                REG_DISPLAY_WIDTH:  display_width_reg  <= cfg_wdata;
                REG_DISPLAY_HEIGHT: display_height_reg <= cfg_wdata;
                REG_TOUCH_MAX_X:    touch_max_x_reg    <= cfg_wdata;
                REG_TOUCH_MAX_Y:    touch_max_y_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // event decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_slot_reg <= '0;
            raw_x_reg        <= '0;
            raw_y_reg        <= '0;
            frame_status_reg <= KIND_MOVE;
        end else if (in_xfer) begin
            if (s_event_type == EVT_KEY) begin
                if (s_event_code == CODE_BTN_TOUCH) begin
                    if (s_event_value == 32'sd1) begin
                        frame_status_reg <= KIND_PRESS;
                    end else if (s_event_value == 32'sd0) begin
                        frame_status_reg <= KIND_RELEASE;
                    end
                end
            end else if (s_event_type == EVT_ABS) begin
                if (s_event_code == CODE_MT_SLOT) begin
                    contact_slot_reg <= s_event_value;
                end else if (contact_slot_reg == '0) begin
                    if (s_event_code == CODE_MT_POS_X) begin
                        raw_x_reg <= s_event_value;
                    end else if (s_event_code == CODE_MT_POS_Y) begin
                        raw_y_reg <= s_event_value;
                    end
                end
            end else if (frame_end) begin
                // every frame end drops back to move, slot or not
                frame_status_reg <= KIND_MOVE;
            end
        end
    end

    // rotation against the touch maximums
    assign xs = {{(POS_W-VAL_W){raw_x_reg[VAL_W-1]}}, raw_x_reg};
    assign ys = {{(POS_W-VAL_W){raw_y_reg[VAL_W-1]}}, raw_y_reg};
    assign mx = {{(POS_W-PIX_W){1'b0}}, touch_max_x_reg};
    assign my = {{(POS_W-PIX_W){1'b0}}, touch_max_y_reg};

    always_comb begin
        case (orientation_reg)
            ORIENT_90: begin
                rx_calc = ys;
                ry_calc = mx - xs;
            end
            ORIENT_180: begin
                rx_calc = mx - xs;
                ry_calc = my - ys;
            end
            ORIENT_270: begin
                rx_calc = my - ys;
                ry_calc = xs;
            end
            default: begin
                rx_calc = xs;
                ry_calc = ys;
            end
        endcase
    end

    // shared multiplier operand select; touch maximum of zero divides by one
    assign mul_op   = axis_reg ? ry_reg : rx_reg;
    assign mul_size = {1'b0, (axis_reg ? size_y_reg : size_x_reg)};
    assign mul_full = mul_op * mul_size;
    assign div_den  = axis_reg ? ((touch_max_y_reg == '0) ? PIX_W'(1) : touch_max_y_reg)
                               : ((touch_max_x_reg == '0) ? PIX_W'(1) : touch_max_x_reg);

    tedrs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (product_reg),
        .den     (div_den),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    // sequencer: next state and strobes
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (emit) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    state_next = axis_reg ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                axis_reg <= 1'b0;
            end else if (state_reg == ST_WAIT && div_stat.done) begin
                axis_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg   <= frame_status_reg;
            rx_reg     <= rx_calc;
            ry_reg     <= ry_calc;
            size_x_reg <= orientation_reg[0] ? display_height_reg : display_width_reg;
            size_y_reg <= orientation_reg[0] ? display_width_reg : display_height_reg;
        end
        if (state_reg == ST_MUL) begin
            product_reg <= mul_full[NUM_W-1:0];
        end
        if (state_reg == ST_WAIT && div_stat.done) begin
            if (axis_reg) begin
                pix_y_reg <= div_quo;
            end else begin
                pix_x_reg <= div_quo;
            end
        end
    end

    assign m_touch_kind = kind_reg;
    assign m_pixel_x    = pix_x_reg;
    assign m_pixel_y    = pix_y_reg;

endmodule

// ----- verif/touch_event_decoder_rotate_scale_tb.sv -----
`timescale 1ns / 100ps

import tedrs_pkg::*;

typedef struct {
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
} touch_point_t;

class touch_frame_model;
    logic [1:0]         orient;
    logic [15:0]        disp_w;
    logic [15:0]        disp_h;
    logic [15:0]        max_x;
    logic [15:0]        max_y;
    logic [31:0]        slot;
    logic signed [31:0] raw_x;
    logic signed [31:0] raw_y;
    logic [1:0]         status;
    touch_point_t       pending_points[$];
    int                 mismatches;

    function new();
        orient     = ORIENT_0;
        disp_w     = 16'd1080;
        disp_h     = 16'd2400;
        max_x      = 16'd4095;
        max_y      = 16'd4095;
        slot       = '0;
        raw_x      = '0;
        raw_y      = '0;
        status     = KIND_MOVE;
        mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] data);
        case (idx)
            REG_ORIENTATION:    orient = data[1:0];
            REG_DISPLAY_WIDTH:  disp_w = data;
            REG_DISPLAY_HEIGHT: disp_h = data;
            REG_TOUCH_MAX_X:    max_x  = data;
            REG_TOUCH_MAX_Y:    max_y  = data;
            default: ;
        endcase
    endfunction

    // product, truncating divide, clamp; divisor 0 reads as 1
    function logic [15:0] scale_axis(longint pos, logic [15:0] size, logic [15:0] maxv);
        longint prod;
        longint divisor;
        longint quot;
        divisor = (maxv == 16'd0) ? 64'sd1 : longint'(maxv);
        prod    = pos * longint'(size);
        if (prod <= 0)
            return 16'd0;
        quot = prod / divisor;
        return (quot > 65535) ? 16'hFFFF : quot[15:0];
    endfunction

    function void take_event(logic [15:0] etype, logic [15:0] ecode, logic signed [31:0] evalue);
        touch_point_t pt;
        longint       mx;
        longint       my;
        longint       rx;
        longint       ry;
        logic [15:0]  w;
        logic [15:0]  h;
        if (etype == EVT_KEY) begin
            if (ecode == CODE_BTN_TOUCH) begin
                if (evalue == 32'sd1)
                    status = KIND_PRESS;
                else if (evalue == 32'sd0)
                    status = KIND_RELEASE;
            end
            return;
        end
        if (etype == EVT_ABS) begin
            if (ecode == CODE_MT_SLOT)
                slot = evalue;
            else if (slot == 32'd0) begin
                if (ecode == CODE_MT_POS_X)
                    raw_x = evalue;
                else if (ecode == CODE_MT_POS_Y)
                    raw_y = evalue;
            end
            return;
        end
        if (etype != EVT_SYN || ecode != CODE_SYN_REPORT || evalue != 32'sd0)
            return;
        pt.kind = status;
        status  = KIND_MOVE;
        if (slot != 32'd0)
            return;
        mx = longint'(max_x);
        my = longint'(max_y);
        case (orient)
            ORIENT_90:  begin rx = raw_y;      ry = mx - raw_x; end
            ORIENT_180: begin rx = mx - raw_x; ry = my - raw_y; end
            ORIENT_270: begin rx = my - raw_y; ry = raw_x;      end
            default:    begin rx = raw_x;      ry = raw_y;      end
        endcase
        if (orient == ORIENT_90 || orient == ORIENT_270) begin
            w = disp_h;
            h = disp_w;
        end else begin
            w = disp_w;
            h = disp_h;
        end
        pt.px = scale_axis(rx, w, max_x);
        pt.py = scale_axis(ry, h, max_y);
        pending_points.insert(pending_points.size(), pt);
    endfunction

    task flag_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task match_point(logic [1:0] kind, logic [15:0] px, logic [15:0] py);
        touch_point_t want;
        if (pending_points.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d x %0d y %0d", kind, px, py));
            return;
        end
        want = pending_points.pop_front();
        if (kind !== want.kind)
            flag_mismatch($sformatf("touch_kind %0d, want %0d", kind, want.kind));
        if (px !== want.px)
            flag_mismatch($sformatf("pixel_x %0d, want %0d", px, want.px));
        if (py !== want.py)
            flag_mismatch($sformatf("pixel_y %0d, want %0d", py, want.py));
    endtask
endclass

module touch_event_decoder_rotate_scale_tb;

    localparam int PHASE_ITEMS = 115;   // random items per configuration phase
    localparam int DRAIN_LIMIT = 20000; // cycles allowed for results to come home
    localparam int TAIL_CYCLES = 60;    // idle tail after the last result is in
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]        cfg_index     = '0;
    logic [PIX_W-1:0]        cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [15:0]             s_event_type  = '0;
    logic [15:0]             s_event_code  = '0;
    logic signed [31:0]      s_event_value = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [1:0]              m_touch_kind;
    logic [PIX_W-1:0]        m_pixel_x;
    logic [PIX_W-1:0]        m_pixel_y;

    touch_frame_model board = new();

    bit steady_send;     // sender runs back to back while set
    bit steady_recv;     // receiver ready outside hold-offs while set
    int results_seen;
    int items_sent;

    touch_event_decoder_rotate_scale u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_event_type  (s_event_type),
        .s_event_code  (s_event_code),
        .s_event_value (s_event_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_touch_kind  (m_touch_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly short gaps, the odd long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinate: mostly on the panel, sometimes wild or right at the edges
    function automatic logic signed [31:0] pick_coord(logic [15:0] lim);
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(0, lim);
        if (r < 18)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sd0;
            1:       return {16'd0, lim};
            2:       return {16'd0, lim} + 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    // one input transfer; the payload is held until s_ready is seen at an edge
    task automatic send_event(logic [15:0] etype, logic [15:0] ecode, logic signed [31:0] evalue);
        int gap;
        gap = pick_gap(steady_send);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_event_type  <= etype;
        s_event_code  <= ecode;
        s_event_value <= evalue;
        do
            @(posedge aclk);
        while (!s_ready);
        board.take_event(etype, ecode, evalue);
        items_sent++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_reg(idx, data);
        @(posedge aclk);
    endtask

    // block is idle here; upper bits of the orientation word must be dropped,
    // and an unused index must change nothing
    task automatic apply_setting(logic [1:0] o, logic [15:0] w, logic [15:0] h,
                                 logic [15:0] mx, logic [15:0] my);
        logic [13:0] junk;
        junk = 14'($urandom);
        write_reg(IDX_W'($urandom_range(int'(REG_TOUCH_MAX_Y) + 1, (1 << IDX_W) - 1)),
                  PIX_W'($urandom));
        write_reg(REG_ORIENTATION, {junk, o});
        write_reg(REG_DISPLAY_WIDTH, w);
        write_reg(REG_DISPLAY_HEIGHT, h);
        write_reg(REG_TOUCH_MAX_X, mx);
        write_reg(REG_TOUCH_MAX_Y, my);
    endtask

    // stop offering, let every expected result arrive, then let the block
    // finish any event that gives no result
    task automatic settle();
        int n;
        s_valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && board.pending_points.size() > 0; n++)
            @(posedge aclk);
        if (board.pending_points.size() > 0) begin
            board.flag_mismatch($sformatf("%0d results never arrived",
                                          board.pending_points.size()));
            board.pending_points.delete();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Random traffic: mostly well-formed protocol B frames with random
    // content (key, other slots, slot 0, X, Y, sync), the rest noise.
    task automatic run_random(int n);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 19) == 0)
                steady_send = !steady_send;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                if ($urandom_range(0, 9) < 6) begin
                    if ($urandom_range(0, 9) == 0)
                        send_event(EVT_KEY, CODE_BTN_TOUCH, $urandom);
                    else
                        send_event(EVT_KEY, CODE_BTN_TOUCH, $urandom_range(0, 1));
                end
                if ($urandom_range(0, 3) == 0) begin
                    // another finger: its coordinates must be ignored
                    if ($urandom_range(0, 1))
                        send_event(EVT_ABS, CODE_MT_SLOT, $urandom_range(1, 9));
                    else
                        send_event(EVT_ABS, CODE_MT_SLOT, $urandom);
                    send_event(EVT_ABS, CODE_MT_POS_X, pick_coord(board.max_x));
                    send_event(EVT_ABS, CODE_MT_POS_Y, pick_coord(board.max_y));
                end
                if ($urandom_range(0, 19) < 17)
                    send_event(EVT_ABS, CODE_MT_SLOT, 32'sd0);
                if ($urandom_range(0, 19) < 17)
                    send_event(EVT_ABS, CODE_MT_POS_X, pick_coord(board.max_x));
                if ($urandom_range(0, 19) < 17)
                    send_event(EVT_ABS, CODE_MT_POS_Y, pick_coord(board.max_y));
                send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);
            end else begin
                case ($urandom_range(0, 4))
                    0, 1: send_event(16'($urandom), 16'($urandom), $urandom);
                    2:    send_event(EVT_ABS, 16'(CODE_MT_SLOT + $urandom_range(0, 8)), $urandom);
                    3: begin
                        if ($urandom_range(0, 1))
                            send_event(EVT_SYN, CODE_SYN_REPORT, $urandom_range(1, 4));
                        else
                            send_event(EVT_SYN, 16'($urandom), $urandom_range(0, 1));
                    end
                    default: send_event(EVT_KEY, 16'($urandom), $urandom_range(0, 2));
                endcase
            end
        end
    endtask

    task automatic run_phase(logic [1:0] o, logic [15:0] w, logic [15:0] h,
                             logic [15:0] mx, logic [15:0] my);
        apply_setting(o, w, h, mx, my);
        run_random(PHASE_ITEMS);
        settle();
    endtask

    // Result side: checks every transfer, idles at random, and once holds
    // off for a long stretch so the block backs up and stalls its input.
    initial begin : result_side
        int  hold_left;
        int  stall_left;
        bit  long_hold_done;
        hold_left      = 0;
        stall_left     = 0;
        long_hold_done = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.match_point(m_touch_kind, m_pixel_x, m_pixel_y);
                results_seen++;
            end
            if (!long_hold_done && results_seen >= 40) begin
                long_hold_done = 1;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 199) == 0)
                    steady_recv = !steady_recv;
                if (steady_recv || $urandom_range(0, 9) < 7) begin
                    m_ready <= 1'b1;
                end else begin
                    stall_left = pick_gap(1'b0);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : event_side
        int k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, at the reset configuration
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);          // move at origin
        send_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd1);
        send_event(EVT_ABS, CODE_MT_POS_X, 32'sd4095);
        send_event(EVT_ABS, CODE_MT_POS_Y, 32'sd4095);
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);          // press at far corner
        send_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd0);
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);          // release
        send_event(EVT_KEY, CODE_BTN_TOUCH, 32'sd2);           // ignored key state
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);
        send_event(EVT_ABS, CODE_MT_POS_X, -32'sd1);           // negative product
        send_event(EVT_ABS, CODE_MT_POS_Y, 32'sh7FFF_FFFF);    // clamps high
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);
        send_event(EVT_ABS, CODE_MT_POS_X, 32'sh8000_0000);
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);
        send_event(EVT_ABS, CODE_MT_SLOT, 32'sd1);
        send_event(EVT_ABS, CODE_MT_POS_X, 32'sd100);          // other slot, dropped
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);          // no result
        send_event(EVT_ABS, CODE_MT_SLOT, 32'sd0);
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd1);          // not a frame end
        send_event(EVT_SYN, 16'h0001, 32'sd0);                 // not a frame end
        send_event(16'h0002, CODE_MT_POS_X, 32'sd5);           // unknown class
        send_event(16'hFFFF, 16'hFFFF, 32'sh8000_0000);
        send_event(EVT_KEY, 16'h0110, 32'sd1);                 // other key
        send_event(EVT_ABS, CODE_MT_POS_Y, 32'sd2048);
        send_event(EVT_SYN, CODE_SYN_REPORT, 32'sd0);
        settle();

        // fixed settings, extremes among them
        run_phase(ORIENT_90,  16'd1080,  16'd2400,  16'd4095,  16'd4095);
        run_phase(ORIENT_180, 16'd1920,  16'd1080,  16'd1023,  16'd767);
        run_phase(ORIENT_270, 16'hFFFF,  16'hFFFF,  16'd1,     16'd1);
        run_phase(ORIENT_0,   16'd1,     16'd1,     16'hFFFF,  16'hFFFF);
        run_phase(ORIENT_90,  16'd800,   16'd480,   16'd0,     16'd0);     // zero maxima
        run_phase(ORIENT_180, 16'hFFFF,  16'd1,     16'hFFFF,  16'd1);
        run_phase(ORIENT_270, 16'd720,   16'd1280,  16'd4095,  16'd2047);

        // random settings
        for (k = 0; k < 6; k++)
            run_phase(2'($urandom_range(0, 3)),
                      16'($urandom_range(0, 1) ? $urandom_range(1, 4000)
                                               : $urandom_range(1, 65535)),
                      16'($urandom_range(0, 1) ? $urandom_range(1, 4000)
                                               : $urandom_range(1, 65535)),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4095)));

        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
